### sv/htp_pkg.sv
// Shared types and constants for the hex template parser.
// Holds the request structs, result codes and character codes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package htp_pkg;

    localparam int unsigned LINE_W  = 20;
    localparam int unsigned COUNT_W = 17;
    localparam int unsigned LIMIT_W = 16;

    localparam logic [LINE_W-1:0]  LINE_MAX  = 20'hFFFFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 17'h10000;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'hFFFF;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_CASE_GAP = 8'h20;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_LOWER_X = 8'h78;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [3:0] LETTER_NIBBLE_ADJ = 4'd9;

    typedef enum logic {
        CMD_CHAR = 1'b0,
        CMD_END  = 1'b1
    } t_command;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_ERROR = 2'd1,
        KIND_END   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ERR_OPEN_RANDOM = 2'd0,
        ERR_OPEN_HEX    = 2'd1,
        ERR_BAD_CHAR    = 2'd2,
        ERR_TOO_LONG    = 2'd3
    } t_err_code;

    typedef struct packed {
        t_command   command;
        logic [7:0] character;
    } t_in_item;

    typedef struct packed {
        t_kind              kind;
        logic [7:0]         data_byte;
        logic               random_flag;
        logic               mask_valid;
        logic [7:0]         mask_byte;
        t_err_code          error_code;
        logic [LINE_W-1:0]  line_number;
        logic [COUNT_W-1:0] byte_count;
    } t_out_item;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] hex_val;
        logic       is_x;
        logic       is_newline;
        logic       is_hash;
        logic       is_blank;
    } t_char_class;

endpackage

`default_nettype wire

### sv/hex_template_parser.sv
// Top level of the hex template parser: request register, parser, result register.
// Depends on htp_pkg, htp_char_decode and htp_parse_core.
`timescale 1ns / 1ps
`default_nettype none

// Takes one text character or end command per cycle and sustains one request
// per clock unless the output stalls; each request passes the input register,
// then the result register. Characters that yield no template byte, error or
// end report produce no result. The length limit is written through i_cfg_we /
// i_cfg_data and should only change while the parser is idle; it resets to 65535.
module hex_template_parser (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [htp_pkg::LIMIT_W-1:0]    i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire htp_pkg::t_in_item              i_in_data,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output htp_pkg::t_out_item                  o_out_data
);

    logic [htp_pkg::LIMIT_W-1:0] r_max_len;
    logic                        r_in_valid;
    htp_pkg::t_in_item           r_in_item;
    logic                        r_out_valid;
    htp_pkg::t_out_item          r_out_item;

    logic                        fire;
    logic                        res_valid;
    htp_pkg::t_out_item          res;
    htp_pkg::t_char_class        char_class;

    assign fire       = r_in_valid && !(r_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && !fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= htp_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_max_len <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_item <= i_in_data;
        end
    end

    htp_char_decode u_decode (
        .i_char  (r_in_item.character),
        .o_class (char_class)
    );

    htp_parse_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (r_in_item),
        .i_class     (char_class),
        .i_max_len   (r_max_len),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= res_valid;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && res_valid) begin
            r_out_item <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

endmodule

`default_nettype wire

### sv/htp_char_decode.sv
// Character classifier: case folding, hex digit value and class flags.
// Depends on htp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module htp_char_decode (
    input  wire logic [7:0]         i_char,
    output htp_pkg::t_char_class    o_class
);

    logic [7:0] folded;
    logic       is_digit;
    logic       is_letter;

    always_comb begin
        if (i_char >= htp_pkg::CH_UPPER_A && i_char <= htp_pkg::CH_UPPER_Z) begin
            folded = i_char + htp_pkg::CH_CASE_GAP;
        end else begin
            folded = i_char;
        end
        is_digit  = (folded >= htp_pkg::CH_DIGIT_0) && (folded <= htp_pkg::CH_DIGIT_9);
        is_letter = (folded >= htp_pkg::CH_LOWER_A) && (folded <= htp_pkg::CH_LOWER_F);

        o_class.is_hex     = is_digit || is_letter;
        o_class.hex_val    = is_letter ? (folded[3:0] + htp_pkg::LETTER_NIBBLE_ADJ)
                                       : folded[3:0];
        o_class.is_x       = (folded == htp_pkg::CH_LOWER_X);
        o_class.is_newline = (folded == htp_pkg::CH_NEWLINE);
        o_class.is_hash    = (folded == htp_pkg::CH_HASH);
        o_class.is_blank   = (folded == htp_pkg::CH_SPACE) ||
                             ((folded >= htp_pkg::CH_TAB) && (folded <= htp_pkg::CH_CR));
    end

endmodule

`default_nettype wire

### sv/htp_parse_core.sv
// Parser state and per-character result logic.
// Depends on htp_pkg; fed by htp_char_decode.
`timescale 1ns / 1ps
`default_nettype none

module htp_parse_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_fire,
    input  wire htp_pkg::t_in_item              i_item,
    input  wire htp_pkg::t_char_class           i_class,
    input  wire logic [htp_pkg::LIMIT_W-1:0]    i_max_len,
    output logic                                o_res_valid,
    output htp_pkg::t_out_item                  o_res
);

    logic                           r_in_random, n_in_random;
    logic                           r_in_comment, n_in_comment;
    logic                           r_pending, n_pending;
    logic [3:0]                     r_high, n_high;
    logic [7:0]                     r_acc, n_acc;
    logic [2:0]                     r_pos, n_pos;
    logic [htp_pkg::LINE_W-1:0]     r_line, n_line;
    logic [htp_pkg::COUNT_W-1:0]    r_bytes, n_bytes;
    logic                           r_err, n_err;

    logic                           emit;
    logic                           emit_rnd;
    logic [7:0]                     emit_val;
    logic [7:0]                     acc_or;
    logic [htp_pkg::LINE_W-1:0]     line_inc;
    logic [htp_pkg::COUNT_W-1:0]    bytes_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_random  <= 1'b0;
            r_in_comment <= 1'b0;
            r_pending    <= 1'b0;
            r_high       <= '0;
            r_acc        <= '0;
            r_pos        <= '0;
            r_line       <= htp_pkg::LINE_W'(1);
            r_bytes      <= '0;
            r_err        <= 1'b0;
        end else if (i_fire) begin
            r_in_random  <= n_in_random;
            r_in_comment <= n_in_comment;
            r_pending    <= n_pending;
            r_high       <= n_high;
            r_acc        <= n_acc;
            r_pos        <= n_pos;
            r_line       <= n_line;
            r_bytes      <= n_bytes;
            r_err        <= n_err;
        end
    end

    assign line_inc  = (r_line < htp_pkg::LINE_MAX) ? r_line + 1'b1 : r_line;
    assign bytes_inc = (r_bytes < htp_pkg::COUNT_MAX) ? r_bytes + 1'b1 : r_bytes;
    assign acc_or    = r_acc | (8'(emit_rnd) << r_pos);

    always_comb begin
        n_in_random  = r_in_random;
        n_in_comment = r_in_comment;
        n_pending    = r_pending;
        n_high       = r_high;
        n_acc        = r_acc;
        n_pos        = r_pos;
        n_line       = r_line;
        n_bytes      = r_bytes;
        n_err        = r_err;
        emit         = 1'b0;
        emit_rnd     = 1'b0;
        emit_val     = '0;
        o_res_valid  = 1'b0;
        o_res        = '0;
        o_res.kind        = htp_pkg::KIND_BYTE;
        o_res.error_code  = htp_pkg::ERR_OPEN_RANDOM;
        o_res.line_number = r_line;
        o_res.byte_count  = r_bytes;

        if (i_item.command == htp_pkg::CMD_END) begin
            if (!r_err) begin
                o_res_valid = 1'b1;
                if (r_bytes > {1'b0, i_max_len}) begin
                    o_res.kind       = htp_pkg::KIND_ERROR;
                    o_res.error_code = htp_pkg::ERR_TOO_LONG;
                end else begin
                    o_res.kind       = htp_pkg::KIND_END;
                    o_res.mask_valid = (r_pos != '0);
                    o_res.mask_byte  = (r_pos != '0) ? r_acc : '0;
                end
            end
            n_in_random  = 1'b0;
            n_in_comment = 1'b0;
            n_pending    = 1'b0;
            n_high       = '0;
            n_acc        = '0;
            n_pos        = '0;
            n_line       = htp_pkg::LINE_W'(1);
            n_bytes      = '0;
            n_err        = 1'b0;
        end else if (!r_err) begin
            priority if (r_in_random) begin
                if (!i_class.is_x) begin
                    n_err            = 1'b1;
                    o_res_valid      = 1'b1;
                    o_res.kind       = htp_pkg::KIND_ERROR;
                    o_res.error_code = htp_pkg::ERR_OPEN_RANDOM;
                end else begin
                    n_in_random = 1'b0;
                end
            end else if (r_in_comment) begin
                if (i_class.is_newline) begin
                    n_in_comment = 1'b0;
                    n_line       = line_inc;
                end
            end else if (i_class.is_hex) begin
                if (r_pending) begin
                    n_pending = 1'b0;
                    emit      = 1'b1;
                    emit_val  = {r_high, i_class.hex_val};
                end else begin
                    n_high    = i_class.hex_val;
                    n_pending = 1'b1;
                end
            end else if (r_pending) begin
                n_err            = 1'b1;
                o_res_valid      = 1'b1;
                o_res.kind       = htp_pkg::KIND_ERROR;
                o_res.error_code = htp_pkg::ERR_OPEN_HEX;
            end else if (i_class.is_newline) begin
                n_line = line_inc;
            end else if (i_class.is_hash) begin
                n_in_comment = 1'b1;
            end else if (i_class.is_x) begin
                n_in_random = 1'b1;
                emit        = 1'b1;
                emit_rnd    = 1'b1;
            end else begin
                if (!i_class.is_blank) begin
                    n_err            = 1'b1;
                    o_res_valid      = 1'b1;
                    o_res.kind       = htp_pkg::KIND_ERROR;
                    o_res.error_code = htp_pkg::ERR_BAD_CHAR;
                end
            end

            if (emit) begin
                o_res_valid       = 1'b1;
                o_res.kind        = htp_pkg::KIND_BYTE;
                o_res.data_byte   = emit_val;
                o_res.random_flag = emit_rnd;
                o_res.byte_count  = bytes_inc;
                n_bytes           = bytes_inc;
                n_pos             = r_pos + 1'b1;
                if (r_pos == 3'd7) begin
                    o_res.mask_valid = 1'b1;
                    o_res.mask_byte  = acc_or;
                    n_acc            = '0;
                end else begin
                    n_acc = acc_or;
                end
            end
        end
    end

endmodule

`default_nettype wire
